FILE: src/mpfs_pkg.sv
// Shared types, constants and byte folding for the multi-pattern string search.
package mpfs_pkg;

    localparam int MPFS_MAX_PATTERNS    = 8;
    localparam int MPFS_MAX_PATTERN_LEN = 16;
    localparam int MPFS_QUEUE_DEPTH     = 8;

    typedef enum logic [1:0] {
        ACT_LOAD_BYTE = 2'd0,
        ACT_SET_LEN   = 2'd1,
        ACT_TEXT      = 2'd2
    } t_action;

    localparam logic REG_IGNORE_CASE = 1'b0;
    localparam logic REG_PATTERNS    = 1'b1;

    typedef struct packed {
        logic [2:0] slot;
        logic [3:0] cpos;
        logic [7:0] data;
    } t_pat_wr;

    typedef struct packed {
        logic        found;
        logic [31:0] match_start;
        logic [31:0] match_end;
        logic [2:0]  pattern;
    } t_result;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        if (en && (c inside {[8'h41:8'h5A]})) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

FILE: src/mpfs_cell.sv
// One window cell: a text byte of the sliding window and one column of the pattern table.
module mpfs_cell #(
    parameter int NPAT = mpfs_pkg::MPFS_MAX_PATTERNS,
    parameter int PLEN = mpfs_pkg::MPFS_MAX_PATTERN_LEN,
    parameter int K    = 0,
    localparam int LEN_W = $clog2(PLEN + 1),
    localparam int WIN_W = (PLEN > 1) ? $clog2(PLEN) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [7:0]                 i_byte,
    output logic [7:0]                 o_byte,
    output logic [7:0]                 o_fold_next,
    input  logic                       i_fold,
    input  logic                       i_wr_en,
    input  mpfs_pkg::t_pat_wr          i_wr,
    input  logic [PLEN-1:0][7:0]       i_window,
    input  logic [NPAT-1:0][LEN_W-1:0] i_lens,
    output logic [NPAT-1:0]            o_hit
);
    import mpfs_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] r_col [NPAT];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
        for (int i = 0; i < NPAT; i++) begin
            if (i_wr_en && (32'(i_wr.cpos) == K) && (32'(i_wr.slot) == i)) begin
                r_col[i] <= i_wr.data;
            end
        end
    end

    assign o_byte      = r_byte;
    assign o_fold_next = fold_byte(i_byte, i_fold);

    always_comb begin
        logic [LEN_W-1:0] j;
        j = '0;
        for (int i = 0; i < NPAT; i++) begin
            if (32'(i_lens[i]) <= K) begin
                o_hit[i] = 1'b1;
            end else begin
                j = i_lens[i] - LEN_W'(K + 1);
                o_hit[i] = (fold_byte(r_col[i], i_fold) == i_window[j[WIN_W-1:0]]);
            end
        end
    end

endmodule

FILE: src/mpfs_queue.sv
// Result queue between the match pipeline and the output channel.
module mpfs_queue #(
    parameter int DEPTH = mpfs_pkg::MPFS_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mpfs_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output mpfs_pkg::t_result o_data,
    output logic [CNT_W-1:0]  o_count
);
    import mpfs_pkg::*;

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = i_pop & o_valid;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(w_pop);
        end
    end

endmodule

FILE: src/multi_pattern_fixed_string_search.sv
// Top level of the multi-pattern fixed-string search.
// Usage: load pattern bytes (action 0) and lengths (action 1) as input beats,
// then stream text bytes (action 2), one beat per cycle while o_ready is high.
// The first text beat of a segment carries the base offset; the beat with last
// set ends the segment. Only that beat yields a result beat: found, start, end
// and winning pattern. ignore_case and patterns_in_use sit on the APB port at
// 0x0 and 0x4. Throughput: one input beat per cycle while o_ready is high.
// Every text beat is compared against all patterns at once by the row of window
// cells in the cycle it is taken. A result passes a compare stage, a winner
// stage, an accumulate stage and the result queue before it is offered.
// Results wait in an eight-entry queue. When the output side stalls, input
// ready drops once queued results plus results in flight reach eight; no
// beat is dropped. Reset sets ignore_case to 0 and patterns_in_use to 1,
// empties the queue and starts a fresh segment; the pattern table holds
// nothing defined until it is loaded.
module multi_pattern_fixed_string_search #(
    parameter int MAX_PATTERNS    = mpfs_pkg::MPFS_MAX_PATTERNS,
    parameter int MAX_PATTERN_LEN = mpfs_pkg::MPFS_MAX_PATTERN_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_slot,
    input  logic [3:0]  i_char_position,
    input  logic [7:0]  i_data_byte,
    input  logic [4:0]  i_pattern_length,
    input  logic [31:0] i_segment_base,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [31:0] o_match_start,
    output logic [31:0] o_match_end,
    output logic [2:0]  o_winning_pattern,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mpfs_pkg::*;

    localparam int P       = MAX_PATTERNS;
    localparam int L       = MAX_PATTERN_LEN;
    localparam int LEN_W   = $clog2(L + 1);
    localparam int IDX_W   = (P > 1) ? $clog2(P) : 1;
    localparam int TREE_LV = (P > 1) ? $clog2(P) : 1;
    localparam int TREE_N  = 1 << TREE_LV;
    localparam int QDEPTH  = MPFS_QUEUE_DEPTH;
    localparam int CNT_W   = $clog2(QDEPTH + 1);

    // configuration
    logic       r_ignore_case;
    logic [3:0] r_patterns;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_case <= 1'b0;
            r_patterns    <= 4'd1;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_IGNORE_CASE: r_ignore_case <= pwdata[0];
                REG_PATTERNS:    r_patterns    <= pwdata[3:0];
                default:         r_patterns    <= r_patterns;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IGNORE_CASE: prdata = {31'd0, r_ignore_case};
            REG_PATTERNS:    prdata = {28'd0, r_patterns};
            default:         prdata = '0;
        endcase
    end

    // input decode
    logic             w_in_acc;
    logic             w_text;
    logic             w_slot_ok;
    logic             w_cpos_ok;
    logic             w_wr_en;
    t_pat_wr          w_wr;
    logic [LEN_W-1:0] w_len_new;

    assign w_in_acc  = i_valid & o_ready;
    assign w_text    = w_in_acc & (i_action == ACT_TEXT);
    assign w_slot_ok = (32'(i_slot) < 32'(P));
    assign w_cpos_ok = (32'(i_char_position) < 32'(L));
    assign w_wr_en   = w_in_acc & (i_action == ACT_LOAD_BYTE) & w_slot_ok & w_cpos_ok;
    assign w_wr      = '{slot: i_slot, cpos: i_char_position, data: i_data_byte};
    assign w_len_new = (32'(i_pattern_length) > 32'(L)) ? LEN_W'(L) : LEN_W'(i_pattern_length);

    logic [P-1:0][LEN_W-1:0] r_len;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < P; i++) begin
            if (w_in_acc && (i_action == ACT_SET_LEN) && (32'(i_slot) == i)) begin
                r_len[i] <= w_len_new;
            end
        end
    end

    // segment tracking
    logic             r_in_seg;
    logic             r_stopped;
    logic [31:0]      r_pos;
    logic [LEN_W-1:0] r_fill;
    logic             w_seg_first;
    logic             w_stop_eff;
    logic [31:0]      w_pos_eff;
    logic [LEN_W-1:0] w_fill_eff;
    logic [LEN_W-1:0] w_fill_new;
    logic             w_byte_ok;
    logic             w_shift;
    logic [31:0]      w_p1;

    assign w_seg_first = ~r_in_seg;
    assign w_stop_eff  = r_in_seg & r_stopped;
    assign w_pos_eff   = r_in_seg ? r_pos : '0;
    assign w_fill_eff  = r_in_seg ? r_fill : '0;
    assign w_fill_new  = (32'(w_fill_eff) == L) ? w_fill_eff : w_fill_eff + LEN_W'(1);
    assign w_byte_ok   = ~w_stop_eff & (i_data_byte != 8'd0);
    assign w_shift     = w_text & w_byte_ok;
    assign w_p1        = w_pos_eff + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seg  <= 1'b0;
            r_stopped <= 1'b0;
            r_pos     <= '0;
            r_fill    <= '0;
        end else if (w_text) begin
            r_in_seg  <= ~i_last;
            r_stopped <= w_stop_eff | (i_data_byte == 8'd0);
            r_pos     <= w_byte_ok ? w_p1 : w_pos_eff;
            r_fill    <= w_byte_ok ? w_fill_new : w_fill_eff;
        end
    end

    // row of window cells
    logic [L-1:0][7:0] w_byte_out;
    logic [L-1:0][7:0] w_byte_in;
    logic [L-1:0][7:0] w_win_f;
    logic [P-1:0]      w_hit [L];

    for (genvar k = 0; k < L; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_byte_in[k] = i_data_byte;
        end else begin : g_body
            assign w_byte_in[k] = w_byte_out[k-1];
        end

        mpfs_cell #(
            .NPAT (P),
            .PLEN (L),
            .K    (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_byte      (w_byte_in[k]),
            .o_byte      (w_byte_out[k]),
            .o_fold_next (w_win_f[k]),
            .i_fold      (r_ignore_case),
            .i_wr_en     (w_wr_en),
            .i_wr        (w_wr),
            .i_window    (w_win_f),
            .i_lens      (r_len),
            .o_hit       (w_hit[k])
        );
    end

    logic [P-1:0]     w_match;
    logic             w_zl_found;
    logic [IDX_W-1:0] w_zl_idx;

    always_comb begin
        logic all;
        logic act;
        all        = 1'b1;
        act        = 1'b0;
        w_zl_found = 1'b0;
        w_zl_idx   = '0;
        for (int i = P - 1; i >= 0; i--) begin
            all = 1'b1;
            for (int k = 0; k < L; k++) begin
                all = all & w_hit[k][i];
            end
            act = (32'(r_patterns) > i);
            w_match[i] = w_byte_ok & act & (r_len[i] != '0) & (r_len[i] <= w_fill_new) & all;
            if (act && (r_len[i] == '0)) begin
                w_zl_found = 1'b1;
                w_zl_idx   = IDX_W'(i);
            end
        end
    end

    // compare stage
    logic                    r1_valid;
    logic                    r1_last;
    logic                    r1_seg_first;
    logic [31:0]             r1_base;
    logic [P-1:0]            r1_match;
    logic [P-1:0][LEN_W-1:0] r1_len;
    logic [31:0]             r1_p1;
    logic                    r1_zl_found;
    logic [IDX_W-1:0]        r1_zl_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= w_text;
        end
        if (w_text) begin
            r1_last      <= i_last;
            r1_seg_first <= w_seg_first;
            r1_base      <= i_segment_base;
            r1_match     <= w_match;
            r1_len       <= r_len;
            r1_p1        <= w_p1;
            r1_zl_found  <= w_seg_first & w_zl_found;
            r1_zl_idx    <= w_zl_idx;
        end
    end

    // winner stage: earliest start is the longest match that does not wrap
    logic             w_nv   [2*TREE_N];
    logic [LEN_W:0]   w_key  [2*TREE_N];
    logic [IDX_W-1:0] w_nidx [2*TREE_N];
    logic [31:0]      w_cand_start;

    always_comb begin
        for (int n = 0; n < 2 * TREE_N; n++) begin
            w_nv[n]   = 1'b0;
            w_key[n]  = '0;
            w_nidx[n] = '0;
        end
        for (int i = 0; i < TREE_N; i++) begin
            if (i < P) begin
                w_nv[TREE_N + i]   = r1_match[i];
                w_key[TREE_N + i]  = {~(r1_p1 < 32'(r1_len[i])), r1_len[i]};
                w_nidx[TREE_N + i] = IDX_W'(i);
            end
        end
        for (int n = TREE_N - 1; n >= 1; n--) begin
            if (w_nv[2*n] && (!w_nv[2*n+1] || (w_key[2*n] >= w_key[2*n+1]))) begin
                w_nv[n]   = 1'b1;
                w_key[n]  = w_key[2*n];
                w_nidx[n] = w_nidx[2*n];
            end else begin
                w_nv[n]   = w_nv[2*n+1];
                w_key[n]  = w_key[2*n+1];
                w_nidx[n] = w_nidx[2*n+1];
            end
        end
    end

    assign w_cand_start = r1_p1 - 32'(w_key[1][LEN_W-1:0]);

    logic             r2_valid;
    logic             r2_last;
    logic             r2_seg_first;
    logic [31:0]      r2_base;
    logic             r2_zl_found;
    logic [IDX_W-1:0] r2_zl_idx;
    logic             r2_cand_found;
    logic [31:0]      r2_cand_start;
    logic [31:0]      r2_cand_end;
    logic [IDX_W-1:0] r2_cand_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        if (r1_valid) begin
            r2_last       <= r1_last;
            r2_seg_first  <= r1_seg_first;
            r2_base       <= r1_base;
            r2_zl_found   <= r1_zl_found;
            r2_zl_idx     <= r1_zl_idx;
            r2_cand_found <= w_nv[1];
            r2_cand_start <= w_cand_start;
            r2_cand_end   <= r1_p1;
            r2_cand_idx   <= w_nidx[1];
        end
    end

    // accumulate stage
    logic             r_best_found;
    logic [31:0]      r_best_start;
    logic [31:0]      r_best_end;
    logic [IDX_W-1:0] r_best_idx;
    logic [31:0]      r_offset;
    logic             r3_last;
    logic             w_b_found;
    logic [31:0]      w_b_start;
    logic [31:0]      w_b_end;
    logic [IDX_W-1:0] w_b_idx;
    logic             w_take;

    always_comb begin
        if (r2_seg_first) begin
            w_b_found = r2_zl_found;
            w_b_start = '0;
            w_b_end   = '0;
            w_b_idx   = r2_zl_found ? r2_zl_idx : '0;
        end else begin
            w_b_found = r_best_found;
            w_b_start = r_best_start;
            w_b_end   = r_best_end;
            w_b_idx   = r_best_idx;
        end
        w_take = r2_cand_found &
                 (!w_b_found || (r2_cand_start < w_b_start) ||
                  ((r2_cand_start == w_b_start) && (r2_cand_idx < w_b_idx)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
            r3_last      <= 1'b0;
        end else begin
            r3_last <= r2_valid & r2_last;
            if (r2_valid) begin
                r_best_found <= w_b_found | w_take;
            end
        end
        if (r2_valid) begin
            r_best_start <= w_take ? r2_cand_start : w_b_start;
            r_best_end   <= w_take ? r2_cand_end : w_b_end;
            r_best_idx   <= w_take ? r2_cand_idx : w_b_idx;
            if (r2_seg_first) begin
                r_offset <= r2_base;
            end
        end
    end

    // result queue
    t_result          n_result;
    t_result          w_head;
    logic [CNT_W-1:0] w_q_count;
    logic [1:0]       w_lasts;

    always_comb begin
        n_result = '0;
        if (r_best_found) begin
            n_result.found       = 1'b1;
            n_result.match_start = r_offset + r_best_start;
            n_result.match_end   = r_offset + r_best_end;
            n_result.pattern     = 3'(r_best_idx);
        end
    end

    mpfs_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r3_last),
        .i_data  (n_result),
        .i_pop   (i_ready),
        .o_valid (o_valid),
        .o_data  (w_head),
        .o_count (w_q_count)
    );

    assign w_lasts = 2'(r1_valid & r1_last) + 2'(r2_valid & r2_last) + 2'(r3_last);
    assign o_ready = (32'(w_q_count) + 32'(w_lasts)) < 32'(QDEPTH);

    assign o_found           = w_head.found;
    assign o_match_start     = w_head.match_start;
    assign o_match_end       = w_head.match_end;
    assign o_winning_pattern = w_head.pattern;

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_q_count) + 32'(w_lasts)) <= 32'(QDEPTH))
        else $error("result queue overcommitted");

    a_nul_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_seg && r_stopped) |=> $stable(r_pos))
        else $error("position moved after NUL");

    a_best_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_found |-> ((r_best_end - r_best_start) <= 32'(L)))
        else $error("best match longer than a pattern");

endmodule

FILE: tb/sv/multi_pattern_fixed_string_search_test.sv
// Self-checking testbench for the multi-pattern fixed-string search block.
module multi_pattern_fixed_string_search_test;
    import mpfs_pkg::*;

    localparam int NPAT = MPFS_MAX_PATTERNS;
    localparam int PLEN = MPFS_MAX_PATTERN_LEN;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int TARGET_BEATS = 750;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = ACT_LOAD_BYTE;
    logic [2:0]  i_slot = '0;
    logic [3:0]  i_char_position = '0;
    logic [7:0]  i_data_byte = '0;
    logic [4:0]  i_pattern_length = '0;
    logic [31:0] i_segment_base = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_found;
    logic [31:0] o_match_start;
    logic [31:0] o_match_end;
    logic [2:0]  o_winning_pattern;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    multi_pattern_fixed_string_search u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_slot           (i_slot),
        .i_char_position  (i_char_position),
        .i_data_byte      (i_data_byte),
        .i_pattern_length (i_pattern_length),
        .i_segment_base   (i_segment_base),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_found          (o_found),
        .o_match_start    (o_match_start),
        .o_match_end      (o_match_end),
        .o_winning_pattern(o_winning_pattern),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]  pat_bytes [NPAT][PLEN];
    logic [4:0]  pat_len [NPAT];
    logic [7:0]  window [PLEN];
    logic [31:0] seg_pos = '0;
    logic [31:0] seg_base = '0;
    int          window_fill = 0;
    bit          seg_open = 1'b0;
    bit          nul_stop = 1'b0;
    bit          have_best = 1'b0;
    logic [31:0] best_start = '0;
    logic [2:0]  best_idx = '0;
    logic [4:0]  best_len = '0;
    bit          cfg_fold = 1'b0;
    logic [3:0]  cfg_active = 4'd1;
    t_result     expected_matches [$];

    int mismatches = 0;
    int beats_sent = 0;
    bit pace_on = 1'b1;
    int rx_wait = 0;
    int holds_asked = 0;
    int holds_taken = 0;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (cfg_fold && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic bit window_holds(input int idx, input int len);
        for (int k = 0; k < len; k++) begin
            if (fold_case(pat_bytes[idx][k]) != fold_case(window[len - 1 - k])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void offer_match(input logic [31:0] start, input int idx, input int len);
        if (!have_best || start < best_start || (start == best_start && idx < best_idx)) begin
            have_best = 1'b1;
            best_start = start;
            best_idx = idx[2:0];
            best_len = len[4:0];
        end
    endfunction

    function automatic void predict_search(input logic [1:0] act, input logic [2:0] slot,
                                           input logic [3:0] cpos, input logic [7:0] data,
                                           input logic [4:0] plen, input logic [31:0] base,
                                           input bit last_beat);
        int      active;
        int      len;
        t_result res;
        active = (cfg_active > NPAT) ? NPAT : int'(cfg_active);
        case (act)
            ACT_LOAD_BYTE: begin
                pat_bytes[slot][cpos] = data;
            end
            ACT_SET_LEN: begin
                pat_len[slot] = (plen > PLEN) ? PLEN[4:0] : plen;
            end
            ACT_TEXT: begin
                if (!seg_open) begin
                    seg_open = 1'b1;
                    seg_base = base;
                    seg_pos = '0;
                    nul_stop = 1'b0;
                    have_best = 1'b0;
                    best_start = '0;
                    best_idx = '0;
                    best_len = '0;
                    window_fill = 0;
                    for (int k = 0; k < PLEN; k++) begin
                        window[k] = 8'h00;
                    end
                    for (int i = 0; i < active; i++) begin
                        if (pat_len[i] == 0) begin
                            offer_match(32'd0, i, 0);
                        end
                    end
                end
                if (!nul_stop) begin
                    if (data == 8'h00) begin
                        nul_stop = 1'b1;
                    end else begin
                        for (int k = PLEN - 1; k > 0; k--) begin
                            window[k] = window[k - 1];
                        end
                        window[0] = data;
                        if (window_fill < PLEN) begin
                            window_fill++;
                        end
                        for (int i = 0; i < active; i++) begin
                            len = int'(pat_len[i]);
                            if (len != 0 && len <= window_fill && window_holds(i, len)) begin
                                offer_match(seg_pos + 32'd1 - 32'(len), i, len);
                            end
                        end
                        seg_pos++;
                    end
                end
                if (last_beat) begin
                    seg_open = 1'b0;
                    res = '0;
                    if (have_best) begin
                        res.found = 1'b1;
                        res.match_start = seg_base + best_start;
                        res.match_end = res.match_start + 32'(best_len);
                        res.pattern = best_idx;
                    end
                    expected_matches.insert(expected_matches.size(), res);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return c + 8'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] pick_pattern_char();
        if ($urandom_range(0, 99) < 4) begin
            return 8'($urandom_range(0, 255));
        end
        return pick_letter();
    endfunction

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 8'h00;
        end
        if (r < 10) begin
            return 8'($urandom_range(0, 255));
        end
        return pick_letter();
    endfunction

    function automatic logic [4:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return 5'd0;
        end
        if (r < 80) begin
            return 5'($urandom_range(1, 4));
        end
        if (r < 90) begin
            return 5'($urandom_range(5, PLEN));
        end
        return 5'($urandom_range(PLEN + 1, 31));
    endfunction

    always @(posedge i_clk) begin
        if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else if (holds_taken != holds_asked) begin
            i_ready <= 1'b0;
            rx_wait <= HOLD_CYCLES;
            holds_taken <= holds_taken + 1;
        end else if (pace_on && $urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
            rx_wait <= pick_gap();
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_matches.size() == 0) begin
                $error("result beat with no expected match pending");
                mismatches++;
            end else begin
                want = expected_matches.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    mismatches++;
                end
                if (o_match_start !== want.match_start) begin
                    $error("match_start: expected %h, got %h", want.match_start, o_match_start);
                    mismatches++;
                end
                if (o_match_end !== want.match_end) begin
                    $error("match_end: expected %h, got %h", want.match_end, o_match_end);
                    mismatches++;
                end
                if (o_winning_pattern !== want.pattern) begin
                    $error("winning_pattern: expected %0d, got %0d", want.pattern,
                           o_winning_pattern);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_beat(input logic [1:0] act, input logic [2:0] slot,
                             input logic [3:0] cpos, input logic [7:0] data,
                             input logic [4:0] plen, input logic [31:0] base,
                             input bit last_beat);
        int gap;
        gap = pace_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_slot <= slot;
        i_char_position <= cpos;
        i_data_byte <= data;
        i_pattern_length <= plen;
        i_segment_base <= base;
        i_last <= last_beat;
        do @(posedge i_clk); while (!o_ready);
        predict_search(act, slot, cpos, data, plen, base, last_beat);
        beats_sent++;
    endtask

    task automatic load_byte(input logic [2:0] slot, input logic [3:0] cpos,
                             input logic [7:0] data);
        send_beat(ACT_LOAD_BYTE, slot, cpos, data, 5'($urandom_range(0, 31)), $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic set_len(input logic [2:0] slot, input logic [4:0] len);
        send_beat(ACT_SET_LEN, slot, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  len, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic text_byte(input logic [7:0] data, input logic [31:0] base,
                             input bit last_beat);
        send_beat(ACT_TEXT, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), data,
                  5'($urandom_range(0, 31)), base, last_beat);
    endtask

    task automatic idle_beat();
        send_beat(ACT_NONE, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IGNORE_CASE: cfg_fold = value[0];
            REG_PATTERNS:    cfg_active = value[3:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic reload_pattern(input logic [2:0] slot);
        logic [4:0] len;
        int         stored;
        len = pick_len();
        stored = (len > PLEN) ? PLEN : int'(len);
        for (int k = 0; k < stored; k++) begin
            load_byte(slot, 4'(k), pick_pattern_char());
        end
        set_len(slot, len);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: idle_beat();
            1: load_byte(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
            default: set_len(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
        endcase
    endtask

    task automatic send_segment();
        int n;
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 4) begin
                send_noise();
            end
            text_byte(pick_text_char(), $urandom, k == n - 1);
        end
    endtask

    task automatic test_table_fill();
        for (int s = 0; s < NPAT; s++) begin
            for (int k = 0; k < PLEN; k++) begin
                load_byte(3'(s), 4'(k), pick_pattern_char());
            end
            set_len(3'(s), pick_len());
        end
    endtask

    task automatic test_corner_cases();
        settle();
        write_reg(REG_PATTERNS, NPAT);
        set_len(3'd0, 5'd0);
        text_byte(8'h00, 32'hFFFF_FFFF, 1'b1);
        load_byte(3'd0, 4'd0, "a");
        load_byte(3'd0, 4'd1, "B");
        set_len(3'd0, 5'd2);
        set_len(3'd1, 5'd31);
        set_len(3'd7, 5'd17);
        load_byte(3'd2, 4'd0, 8'h00);
        set_len(3'd2, 5'd1);
        load_byte(3'd7, 4'd15, 8'hFF);
        idle_beat();
        text_byte("x", 32'hFFFF_FFFE, 1'b0);
        text_byte("A", 32'h0000_0000, 1'b0);
        text_byte("b", 32'hFFFF_FFFF, 1'b1);
        settle();
        write_reg(REG_IGNORE_CASE, 32'd1);
        text_byte("x", 32'hFFFF_FFFE, 1'b0);
        text_byte("A", 32'h0000_0000, 1'b0);
        text_byte("b", 32'hFFFF_FFFF, 1'b1);
        text_byte("a", $urandom, 1'b0);
        text_byte(8'h00, $urandom, 1'b0);
        text_byte("B", $urandom, 1'b1);
        settle();
        write_reg(REG_PATTERNS, 32'd0);
        text_byte("a", 32'h0000_0000, 1'b1);
        settle();
        write_reg(REG_PATTERNS, 32'd15);
        text_byte("a", 32'h8000_0000, 1'b0);
        settle();
        write_reg(REG_IGNORE_CASE, 32'd0);
        text_byte("B", $urandom, 1'b1);
        settle();
        write_reg(REG_PATTERNS, 32'd1);
    endtask

    task automatic test_back_pressure();
        settle();
        pace_on <= 1'b0;
        holds_asked <= holds_asked + 1;
        repeat (30) text_byte(pick_text_char(), $urandom, 1'b1);
        settle();
        pace_on <= 1'b1;
    endtask

    task automatic test_random_traffic();
        int phase;
        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            settle();
            write_reg(REG_IGNORE_CASE, $urandom_range(0, 1));
            write_reg(REG_PATTERNS, (phase == 0) ? 1 : (phase == 1) ? NPAT : $urandom_range(1, NPAT));
            pace_on <= (phase % 4) != 3;
            repeat (2) reload_pattern(3'($urandom_range(0, NPAT - 1)));
            repeat (6) begin
                if ($urandom_range(0, 9) == 0) begin
                    idle_beat();
                end
                send_segment();
            end
            phase++;
        end
        settle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_table_fill();
        test_corner_cases();
        test_back_pressure();
        test_random_traffic();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
